@@ rtl/lkvc_pkg.sv @@
// Shared types, constants and helpers for the LRU key-value cache.
package lkvc_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int KEY_BITS      = 32;
   localparam int DATA_BITS     = 32;
   localparam int RANK_BITS     = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_BITS      = 5;
   localparam int CMP_BITS      = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(10);

   // register select is csr_paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [1:0] REQ_GET    = 2'd0;
   localparam logic [1:0] REQ_PUT    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } lkvc_rsp_type;

   typedef struct packed {
      logic                  fire;
      logic [COUNT_BITS-1:0] cap;
   } lkvc_op_type;

   function automatic logic [KEY_BITS-1:0] to_key(input logic signed [31:0] key);
      logic signed [63:0] ext;
      ext = 64'(key);
      return ext[KEY_BITS-1:0];
   endfunction

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level: request register, result register, capacity register and entry store.
//
//   channel   direction  handshake                  payload
//   req_*     in         req_valid / req_stall      lkvc_req_type: req_type, key, value
//   rsp_*     out        rsp_valid / rsp_stall      lkvc_rsp_type: hit, read_value
//   csr_*     in/out     psel, penable, pready      capacity at byte address 0
//
// One request per cycle while results are not stalled; a taken request waits in the request
// register; key match and rank update are combinational; the result register captures it.
// Reset is synchronous: all entries invalid, capacity back to 10.
// A stalled result holds the request register, which then stalls req_* in the same cycle.
module lru_key_value_cache (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lkvc_pkg::lkvc_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lkvc_pkg::lkvc_rsp_type                rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import lkvc_pkg::*;

   logic                  req_valid_ff, req_valid_in;
   lkvc_req_type          req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   lkvc_rsp_type          rsp_ff, store_rsp;
   logic [CAP_BITS-1:0]   capacity_ff, capacity_in;
   logic [CMP_BITS-1:0]   cap_wide, cap_clamped;
   lkvc_op_type           op;
   logic                  fire, accept, csr_write;

   assign fire         = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !fire;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready
                        && (csr_paddr[2] == REG_CAPACITY);
   assign capacity_in = csr_write ? csr_pwdata[CAP_BITS-1:0] : capacity_ff;
   assign csr_prdata  = (csr_paddr[2] == REG_CAPACITY) ?
                        CSR_DATA_BITS'(capacity_ff) : '0;

   always_comb begin
      cap_wide = CMP_BITS'(capacity_ff);
      if (cap_wide == '0) begin
         cap_clamped = CMP_BITS'(1);
      end else if (cap_wide > CMP_BITS'(MAX_ENTRIES)) begin
         cap_clamped = CMP_BITS'(MAX_ENTRIES);
      end else begin
         cap_clamped = cap_wide;
      end
   end

   assign op.fire = fire;
   assign op.cap  = cap_clamped[COUNT_BITS-1:0];

   lkvc_store u_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .req   (req_ff),
      .rsp   (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= store_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/lkvc_store.sv @@
// Entry store: parallel key match, recency ranks, insert, evict and remove.
module lkvc_store (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_pkg::lkvc_op_type  op,
   input  lkvc_pkg::lkvc_req_type req,
   output lkvc_pkg::lkvc_rsp_type rsp
);
   import lkvc_pkg::*;

   logic [KEY_BITS-1:0]   key_ff   [MAX_ENTRIES];
   logic [DATA_BITS-1:0]  value_ff [MAX_ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff  [MAX_ENTRIES];
   logic [RANK_BITS-1:0]  rank_in  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [COUNT_BITS-1:0] used_ff, used_in, used_less;

   logic [KEY_BITS-1:0]    k;
   logic [MAX_ENTRIES-1:0] match, victim, free, slot, wr_value, wr_key;
   logic [RANK_BITS-1:0]   last_rank, hit_rank;
   logic [DATA_BITS-1:0]   hit_value;
   logic                   hit_any, is_get, is_put, is_remove, evict;

   assign k         = to_key(req.key);
   assign used_less = used_ff - COUNT_BITS'(1);
   assign last_rank = used_less[RANK_BITS-1:0];
   assign is_get    = (req.req_type == REQ_GET);
   assign is_put    = (req.req_type == REQ_PUT);
   assign is_remove = (req.req_type == REQ_REMOVE);

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == k);
         victim[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         hit_rank  = hit_rank  | (match[i] ? rank_ff[i]  : '0);
         hit_value = hit_value | (match[i] ? value_ff[i] : '0);
      end
   end

   assign hit_any = |match;
   assign evict   = is_put && !hit_any && (used_ff >= op.cap);
   assign free    = ~valid_ff | (evict ? victim : '0);
   assign slot    = free & (~free + MAX_ENTRIES'(1));

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      wr_value = '0;
      wr_key   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      case (req.req_type)
         REQ_GET, REQ_PUT: begin
            if (hit_any) begin
               // touch: younger entries age by one, the hit entry becomes newest
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (match[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                     rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                  end
               end
               if (is_put) begin
                  wr_value = match;
               end
            end else if (is_put) begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (slot[i]) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                  end else if (evict && victim[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                  end
               end
               wr_value = slot;
               wr_key   = slot;
               if (!evict) begin
                  used_in = used_ff + COUNT_BITS'(1);
               end
            end
         end
         REQ_REMOVE: begin
            if (hit_any) begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (match[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i] && rank_ff[i] > hit_rank) begin
                     rank_in[i] = rank_ff[i] - RANK_BITS'(1);
                  end
               end
               used_in = used_less;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (op.fire) begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.fire) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (wr_key[i]) begin
               key_ff[i] <= k;
            end
            if (wr_value[i]) begin
               value_ff[i] <= DATA_BITS'(req.value);
            end
         end
      end
   end

   always_comb begin
      rsp.hit        = hit_any && (is_get || is_put || is_remove);
      rsp.read_value = (is_get && hit_any) ? $signed(hit_value) : '0;
   end

endmodule

@@ tb/lkvc_checker.sv @@
// Checker for the LRU key-value cache: watches all ports, predicts results and compares them.
module lkvc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  lkvc_pkg::lkvc_req_type             req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  lkvc_pkg::lkvc_rsp_type             rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic                               csr_pready,
   input  logic [lkvc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output int                                 pending,
   output int                                 fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   logic [KEY_BITS-1:0]  ent_key  [MAX_ENTRIES];
   logic [DATA_BITS-1:0] ent_val  [MAX_ENTRIES];
   logic                 ent_vld  [MAX_ENTRIES];
   int                   ent_rank [MAX_ENTRIES];
   int                   used;
   logic [CAP_BITS-1:0]  capacity;
   lkvc_rsp_type         due_q [$];
   int                   fails = 0;

   assign fail_count = fails;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %h, want %h", $realtime, what, got, want);
      fails++;
   endtask

   function automatic int free_slot();
      int i;
      for (i = 0; i < MAX_ENTRIES; i++)
         if (!ent_vld[i]) return i;
      return -1;
   endfunction

   // make entry i the most recent
   function automatic void promote(input int i);
      int j;
      for (j = 0; j < MAX_ENTRIES; j++)
         if (ent_vld[j] && ent_rank[j] < ent_rank[i]) ent_rank[j]++;
      ent_rank[i] = 0;
   endfunction

   // delete entry i and close the gap in the ranks
   function automatic void evict(input int i);
      int j;
      ent_vld[i] = 1'b0;
      for (j = 0; j < MAX_ENTRIES; j++)
         if (ent_vld[j] && ent_rank[j] > ent_rank[i]) ent_rank[j]--;
      ent_rank[i] = 0;
      if (used > 0) used--;
   endfunction

   function automatic lkvc_rsp_type lru_access(input lkvc_req_type r);
      lkvc_rsp_type        res;
      logic [KEY_BITS-1:0] k;
      int                  i, idx, slot, lru, limit;
      res   = '0;
      k     = KEY_BITS'(r.key);
      idx   = -1;
      limit = (capacity == 0) ? 1 : (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
      for (i = 0; i < MAX_ENTRIES; i++)
         if (idx < 0 && ent_vld[i] && ent_key[i] == k) idx = i;
      case (r.req_type)
         REQ_GET: begin
            if (idx >= 0) begin
               res.hit        = 1'b1;
               res.read_value = ent_val[idx];
               promote(idx);
            end
         end
         REQ_PUT: begin
            if (idx >= 0) begin
               res.hit      = 1'b1;
               ent_val[idx] = r.value;
               promote(idx);
            end else begin
               slot = (used < limit) ? free_slot() : -1;
               if (slot < 0) begin
                  lru = -1;
                  for (i = 0; i < MAX_ENTRIES; i++)
                     if (ent_vld[i] && (lru < 0 || ent_rank[i] > ent_rank[lru])) lru = i;
                  if (lru >= 0) evict(lru);
                  slot = free_slot();
               end
               if (slot >= 0) begin
                  for (i = 0; i < MAX_ENTRIES; i++)
                     if (ent_vld[i]) ent_rank[i]++;
                  ent_vld[slot]  = 1'b1;
                  ent_key[slot]  = k;
                  ent_val[slot]  = r.value;
                  ent_rank[slot] = 0;
                  used++;
               end
            end
         end
         REQ_REMOVE: begin
            if (idx >= 0) begin
               res.hit = 1'b1;
               evict(idx);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      lkvc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            ent_key[i]  = '0;
            ent_val[i]  = '0;
            ent_vld[i]  = 1'b0;
            ent_rank[i] = 0;
         end
         used     = 0;
         capacity = CAP_RESET;
         due_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_CAPACITY) begin
            if (csr_pwrite)
               capacity = csr_pwdata[CAP_BITS-1:0];
            else if (csr_prdata[CAP_BITS-1:0] !== capacity)
               report_mismatch("capacity read", csr_prdata, 32'(capacity));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_data.hit), rsp_data.read_value);
            end else begin
               want = due_q[0];
               due_q.delete(0);
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_data.hit), 32'(want.hit));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_data.read_value, want.read_value);
            end
         end
         if (req_valid && !req_stall) due_q = {due_q, lru_access(req_data)};
      end
      pending <= due_q.size();
   end

endmodule

@@ tb/tb.sv @@
// Testbench top for the LRU key-value cache: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   localparam logic [1:0] REQ_IGNORED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   lkvc_req_type             req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   lkvc_rsp_type             rsp_data;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       pending;
   int                       fail_count;
   int                       cycle_count = 0;
   int                       stall_left  = 0;
   int                       stall_odds  = 0;
   int                       gap_odds    = 0;
   bit                       calm        = 1'b0;
   logic [31:0]              key_pool [24];
   int                       pool_size;

   lru_key_value_cache DUT (.*);

   lkvc_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || calm || stall_odds == 0) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(1, 15);
      end
      rsp_stall <= (stall_left != 0);
   end

   task automatic send_req(input logic [1:0] kind, input logic [31:0] k, input logic [31:0] v);
      lkvc_req_type r;
      r.req_type = kind;
      r.key      = k;
      r.value    = v;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] cap, input logic [26:0] upper);
      csr_access(1'b1, {upper, cap});
      csr_access(1'b0, '0);
   endtask

   task automatic random_phase(input int count);
      int          pick;
      logic [1:0]  kind;
      logic [31:0] k;
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 40) ? REQ_GET : (pick < 80) ? REQ_PUT :
                (pick < 95) ? REQ_REMOVE : REQ_IGNORED;
         k    = ($urandom_range(0, 9) == 0) ? $urandom() :
                key_pool[$urandom_range(0, pool_size - 1)];
         send_req(kind, k, $urandom());
         if ($urandom_range(0, 49) == 0) begin
            gap_odds   = $urandom_range(0, 3) * 5;
            stall_odds = $urandom_range(0, 3) * 5;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, '0);
      gap_odds   = 4;
      stall_odds = 4;

      send_req(REQ_GET,     32'h0000_0000, 32'h1234_5678);
      send_req(REQ_PUT,     32'h8000_0000, 32'h7FFF_FFFF);
      send_req(REQ_PUT,     32'h7FFF_FFFF, 32'h8000_0000);
      send_req(REQ_PUT,     32'h0000_0000, 32'h0000_0000);
      send_req(REQ_PUT,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(REQ_GET,     32'h8000_0000, 32'h0);
      send_req(REQ_GET,     32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_req(REQ_PUT,     32'h0000_0000, 32'h0000_0005);
      send_req(REQ_GET,     32'h0000_0000, 32'h0);
      send_req(REQ_REMOVE,  32'hFFFF_FFFF, 32'h0);
      send_req(REQ_REMOVE,  32'hFFFF_FFFF, 32'h0);
      send_req(REQ_GET,     32'hFFFF_FFFF, 32'h0);
      send_req(REQ_IGNORED, 32'h0000_0000, 32'hDEAD_BEEF);
      send_req(REQ_REMOVE,  32'h5555_5555, 32'h0);
      for (int i = 1; i <= 9; i++) send_req(REQ_PUT, 32'(i), 32'hAAAA_AAAA ^ 32'(i));
      send_req(REQ_GET,     32'h7FFF_FFFF, 32'h0);
      send_req(REQ_GET,     32'h8000_0000, 32'h0);
      drain();

      // capacity dropped below the entries in use
      set_capacity(5'd3, '0);
      random_phase(125);
      drain();
      set_capacity(5'd16, '0);
      random_phase(125);
      drain();
      set_capacity(5'd0, 27'h7FF_FFFF);
      random_phase(125);
      drain();
      set_capacity(5'd1, '0);
      random_phase(125);
      drain();
      set_capacity(5'd31, '0);
      random_phase(125);
      drain();
      set_capacity(5'd17, 27'($urandom()));
      random_phase(125);
      drain();
      set_capacity(5'd2, '0);
      random_phase(125);
      drain();
      set_capacity(5'($urandom_range(0, 31)), 27'($urandom()));
      random_phase(125);
      drain();

      calm = 1'b1;
      set_capacity(5'd10, '0);
      random_phase(100);
      drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
